### sv/krhc_pkg.sv
// Shared types and constants for the k-mer rolling hash counter.
`timescale 1ns / 1ps

package krhc_pkg;

    // Default build parameters.
    localparam int KMER_LEN_DEF    = 8;
    localparam int COUNT_WIDTH_DEF = 16;

    // Fixed field widths.
    localparam int SLOT_W  = 16;
    localparam int POS_W   = 32;
    localparam int RUN_W   = 4;
    localparam int BASE_W  = 8;
    localparam int OCNT_W  = 16;

    // Action codes carried on the input tuser.
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // Lower-case nucleotide letters; bit 5 forces lower case.
    localparam logic [BASE_W-1:0] CASE_BIT = 8'h20;
    localparam logic [BASE_W-1:0] NUC_A    = 8'h61;
    localparam logic [BASE_W-1:0] NUC_C    = 8'h63;
    localparam logic [BASE_W-1:0] NUC_G    = 8'h67;
    localparam logic [BASE_W-1:0] NUC_T    = 8'h74;

    // One table request travelling down the pipeline.
    typedef struct packed {
        logic              is_read;
        logic [SLOT_W-1:0] slot;
        logic [POS_W-1:0]  start_pos;
    } req_t;

endpackage

### sv/kmer_rolling_hash_counter.sv
// Top level of the k-mer rolling hash counter.
`timescale 1ns / 1ps

// Usage:
// The input stream carries one request per transfer. s_tuser[0] selects the
// action: a push of one reference base (s_tdata[7:0]) or a read of one count
// table entry (s_tdata[23:8]). s_tuser[1] marks the first base of a sequence.
// Each push that completes a k-mer, and every read, yields one result on the
// output stream: m_tuser[0] flags a read reply, m_tdata holds the k-mer code
// (or read index), the k-mer start position and the count. Invalid bases and
// pushes with a short run yield nothing.
// A request passes stage A, stage B and the output register. One request is
// taken every cycle while s_tready is high; a downstream stall or the sweep
// drops it. The count table is read as a request moves from stage A to stage
// B and written back as it moves on, with the last write forwarded so that
// consecutive hits on one entry count correctly. After reset the table is
// swept to zero, one entry per cycle; s_tready stays low during the sweep.
// When the receiver stalls, results fill free stages before s_tready drops.
module kmer_rolling_hash_counter #(
    parameter int KMER_LEN    = krhc_pkg::KMER_LEN_DEF,
    parameter int COUNT_WIDTH = krhc_pkg::COUNT_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // base[7:0], read_index[23:8]
    input  logic [1:0]  s_tuser,   // action[0], first_of_sequence[1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // kmer_code[15:0], start_position[47:16], count[63:48]
    output logic [0:0]  m_tuser    // is_read_reply[0]
);

    localparam int EXT_W = (COUNT_WIDTH > krhc_pkg::OCNT_W) ? COUNT_WIDTH : krhc_pkg::OCNT_W;

    logic                         s_accept;
    logic                         clearing;
    logic                         req_valid;
    krhc_pkg::req_t               req;

    logic                         a_v_reg, a_v_next;
    krhc_pkg::req_t               a_req_reg;
    logic                         b_v_reg, b_v_next;
    krhc_pkg::req_t               b_req_reg;
    logic                         o_v_reg, o_v_next;
    krhc_pkg::req_t               o_req_reg;
    logic [krhc_pkg::OCNT_W-1:0]  o_cnt_reg;

    logic                         out_en, b_en, a_en;
    logic                         rd_en, wr_en;
    logic [COUNT_WIDTH-1:0]       rd_data;
    logic                         lw_v_reg;
    logic [krhc_pkg::SLOT_W-1:0]  lw_addr_reg;
    logic [COUNT_WIDTH-1:0]       lw_data_reg;
    logic [COUNT_WIDTH-1:0]       cur_cnt, new_cnt, shown_cnt;
    logic [EXT_W-1:0]             ext_cnt;
    logic [krhc_pkg::OCNT_W-1:0]  sat_cnt;

    // Stage enables: each stage moves when the one after it has room.
    assign out_en   = !o_v_reg || m_tready;
    assign b_en     = !b_v_reg || out_en;
    assign a_en     = !a_v_reg || b_en;
    assign s_tready = a_en && !clearing;
    assign s_accept = s_tvalid && s_tready;

    krhc_window #(
        .KMER_LEN (KMER_LEN)
    ) u_window (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .accept            (s_accept),
        .action            (s_tuser[0]),
        .base              (s_tdata[7:0]),
        .first_of_sequence (s_tuser[1]),
        .read_index        (s_tdata[23:8]),
        .req_valid         (req_valid),
        .req               (req)
    );

    // The table is read as a request moves from stage A to stage B.
    assign rd_en = b_en && a_v_reg;

    krhc_table #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (rd_en),
        .rd_addr  (a_req_reg.slot),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (b_req_reg.slot),
        .wr_data  (new_cnt),
        .clearing (clearing)
    );

    // Forward the most recent write, then increment with saturation.
    always_comb begin
        cur_cnt   = (lw_v_reg && (lw_addr_reg == b_req_reg.slot)) ? lw_data_reg : rd_data;
        new_cnt   = (&cur_cnt) ? cur_cnt : cur_cnt + 1'b1;
        shown_cnt = b_req_reg.is_read ? cur_cnt : new_cnt;
        ext_cnt   = EXT_W'(shown_cnt);
        sat_cnt   = (ext_cnt > EXT_W'({krhc_pkg::OCNT_W{1'b1}})) ?
                    {krhc_pkg::OCNT_W{1'b1}} : ext_cnt[krhc_pkg::OCNT_W-1:0];
        wr_en     = b_v_reg && out_en && !b_req_reg.is_read;
    end

    // Valid bits of the three stages.
    always_comb begin
        a_v_next = a_v_reg;
        b_v_next = b_v_reg;
        o_v_next = o_v_reg;
        if (a_en) begin
            a_v_next = req_valid;
        end
        if (b_en) begin
            b_v_next = a_v_reg;
        end
        if (out_en) begin
            o_v_next = b_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg  <= 1'b0;
            b_v_reg  <= 1'b0;
            o_v_reg  <= 1'b0;
            lw_v_reg <= 1'b0;
        end else begin
            a_v_reg <= a_v_next;
            b_v_reg <= b_v_next;
            o_v_reg <= o_v_next;
            if (wr_en) begin
                lw_v_reg <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (a_en) begin
            a_req_reg <= req;
        end
        if (b_en) begin
            b_req_reg <= a_req_reg;
        end
        if (out_en) begin
            o_req_reg <= b_req_reg;
            o_cnt_reg <= sat_cnt;
        end
        if (wr_en) begin
            lw_addr_reg <= b_req_reg.slot;
            lw_data_reg <= new_cnt;
        end
    end

    assign m_tvalid   = o_v_reg;
    assign m_tuser[0] = o_req_reg.is_read;
    assign m_tdata    = {o_cnt_reg, o_req_reg.start_pos, o_req_reg.slot};

`ifndef SYNTHESIS
    // No request enters while the table is being swept.
    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !s_tready)
        else $error("request accepted during clearing pass");
    // A reported k-mer has been counted at least once.
    a_push_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (o_v_reg && !o_req_reg.is_read) |-> o_cnt_reg != '0)
        else $error("k-mer result with zero count");
    // A read reply always carries position zero.
    a_read_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (o_v_reg && o_req_reg.is_read) |-> o_req_reg.start_pos == '0)
        else $error("read reply with nonzero position");
`endif

endmodule

### sv/krhc_window.sv
// Rolling k-mer window, run length and position tracking.
`timescale 1ns / 1ps

module krhc_window #(
    parameter int KMER_LEN = krhc_pkg::KMER_LEN_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic                          action,
    input  logic [krhc_pkg::BASE_W-1:0]   base,
    input  logic                          first_of_sequence,
    input  logic [krhc_pkg::SLOT_W-1:0]   read_index,
    output logic                          req_valid,
    output krhc_pkg::req_t                req
);

    localparam int CODE_W = 2 * KMER_LEN;

    logic [CODE_W-1:0]            window_reg, window_next;
    logic [krhc_pkg::RUN_W-1:0]   run_reg, run_next;
    logic [krhc_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [krhc_pkg::RUN_W-1:0]   run_start;
    logic [krhc_pkg::POS_W-1:0]   pos_cur;
    logic [krhc_pkg::BASE_W-1:0]  lower;
    logic                         base_ok;

    // Classify the base and roll the window; the oldest base drops off the top.
    always_comb begin
        lower     = base | krhc_pkg::CASE_BIT;
        base_ok   = (lower == krhc_pkg::NUC_A) || (lower == krhc_pkg::NUC_C) ||
                    (lower == krhc_pkg::NUC_G) || (lower == krhc_pkg::NUC_T);
        run_start = first_of_sequence ? '0 : run_reg;
        pos_cur   = first_of_sequence ? '0 : pos_reg;

        window_next = window_reg;
        run_next    = run_reg;
        pos_next    = pos_reg;
        if (accept && (action == krhc_pkg::ACT_PUSH)) begin
            pos_next = pos_cur + 1'b1;
            if (base_ok) begin
                window_next = CODE_W'({window_reg, base[2:1]});
                run_next    = (run_start < krhc_pkg::RUN_W'(KMER_LEN)) ?
                              run_start + 1'b1 : run_start;
            end else begin
                run_next = '0;
            end
        end
    end

    // Form the table request for this item.
    always_comb begin
        req.is_read   = (action == krhc_pkg::ACT_READ);
        req.slot      = req.is_read ? read_index : krhc_pkg::SLOT_W'(window_next);
        req.start_pos = req.is_read ? '0 :
                        pos_cur - krhc_pkg::POS_W'(KMER_LEN - 1);
        req_valid     = accept && (req.is_read ||
                        (base_ok && (run_next == krhc_pkg::RUN_W'(KMER_LEN))));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
            run_reg    <= '0;
            pos_reg    <= '0;
        end else begin
            window_reg <= window_next;
            run_reg    <= run_next;
            pos_reg    <= pos_next;
        end
    end

`ifndef SYNTHESIS
    // The run never exceeds the k-mer length.
    a_run_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        run_reg <= krhc_pkg::RUN_W'(KMER_LEN))
        else $error("run length above k-mer length");
    // A read changes no window state.
    a_read_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && action == krhc_pkg::ACT_READ) |=> $stable(pos_reg) && $stable(run_reg))
        else $error("read request changed window state");
    // A completed k-mer always comes from a full run.
    a_hit_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (req_valid && !req.is_read) |=> run_reg == krhc_pkg::RUN_W'(KMER_LEN))
        else $error("k-mer reported from partial run");
`endif

endmodule

### sv/krhc_table.sv
// Count table memory with a clearing pass after reset.
`timescale 1ns / 1ps

module krhc_table #(
    parameter int COUNT_WIDTH = krhc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          rd_en,
    input  logic [krhc_pkg::SLOT_W-1:0]   rd_addr,
    output logic [COUNT_WIDTH-1:0]        rd_data,
    input  logic                          wr_en,
    input  logic [krhc_pkg::SLOT_W-1:0]   wr_addr,
    input  logic [COUNT_WIDTH-1:0]        wr_data,
    output logic                          clearing
);

    localparam int DEPTH = 1 << krhc_pkg::SLOT_W;

    logic [COUNT_WIDTH-1:0]       mem [DEPTH];
    logic                         clear_reg, clear_next;
    logic [krhc_pkg::SLOT_W-1:0]  clr_addr_reg, clr_addr_next;
    logic                         w_en;
    logic [krhc_pkg::SLOT_W-1:0]  w_addr;
    logic [COUNT_WIDTH-1:0]       w_data;

    assign clearing = clear_reg;

    // Sweep every entry to zero, one per cycle, after reset.
    always_comb begin
        clr_addr_next = clr_addr_reg;
        clear_next    = clear_reg;
        if (clear_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (&clr_addr_reg) begin
                clear_next = 1'b0;
            end
        end
        w_en   = clear_reg || wr_en;
        w_addr = clear_reg ? clr_addr_reg : wr_addr;
        w_data = clear_reg ? '0 : wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_reg    <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            clear_reg    <= clear_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // Single-port-style write, registered read.
    always_ff @(posedge aclk) begin
        if (w_en) begin
            mem[w_addr] <= w_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

`ifndef SYNTHESIS
    // Normal traffic never writes during the sweep.
    a_no_wr_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !(clear_reg && wr_en))
        else $error("table write during clearing pass");
    // Normal traffic never reads during the sweep.
    a_no_rd_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !(clear_reg && rd_en))
        else $error("table read during clearing pass");
    // The sweep finishes only after the last entry.
    a_clear_end: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(clear_reg) |-> clr_addr_reg == '0)
        else $error("clearing pass ended early");
`endif

endmodule

### tb/kmer_rolling_hash_counter_test.sv
// Self-checking testbench for the k-mer rolling hash counter.
`timescale 1ns / 1ps

module kmer_rolling_hash_counter_test;

    localparam int KMER_LEN     = krhc_pkg::KMER_LEN_DEF;
    localparam int COUNT_WIDTH  = krhc_pkg::COUNT_WIDTH_DEF;
    localparam int TABLE_DEPTH  = 1 << krhc_pkg::SLOT_W;
    localparam int RANDOM_ITEMS = 900;
    localparam longint TIMEOUT_NS = 64'd12_000_000;

    // Byte that is never a nucleotide, in either case.
    localparam logic [krhc_pkg::BASE_W-1:0] NOT_A_BASE = 8'h4E;
    // Letter for each 2-bit base code: A=0, C=1, T=2, G=3.
    localparam logic [krhc_pkg::BASE_W-1:0] LETTER_OF_CODE [4] =
        '{krhc_pkg::NUC_A, krhc_pkg::NUC_C, krhc_pkg::NUC_T, krhc_pkg::NUC_G};

    // One result as it leaves the block.
    typedef struct packed {
        logic                        is_read;
        logic [krhc_pkg::SLOT_W-1:0] code;
        logic [krhc_pkg::POS_W-1:0]  start;
        logic [krhc_pkg::OCNT_W-1:0] count;
    } kmer_reply_t;

    // Tracks the k-mer window and count table, and checks results in order.
    class kmer_tally;
        logic [31:0]                 window;
        int unsigned                 run_len;
        logic [krhc_pkg::POS_W-1:0]  next_pos;
        logic [COUNT_WIDTH-1:0]      counts [TABLE_DEPTH];
        kmer_reply_t                 pending [$];
        logic [krhc_pkg::SLOT_W-1:0] seen_slots [$];
        int unsigned                 mismatches;
        int unsigned                 push_count;
        int unsigned                 read_count;
        int unsigned                 kmer_results;
        int unsigned                 read_replies;

        function new();
            window = '0;
            run_len = 0;
            next_pos = '0;
            mismatches = 0;
            push_count = 0;
            read_count = 0;
            kmer_results = 0;
            read_replies = 0;
            for (int i = 0; i < TABLE_DEPTH; i++) counts[i] = '0;
        endfunction

        static function bit is_nucleotide(input logic [krhc_pkg::BASE_W-1:0] b);
            logic [krhc_pkg::BASE_W-1:0] lower;
            lower = b | krhc_pkg::CASE_BIT;
            return lower == krhc_pkg::NUC_A || lower == krhc_pkg::NUC_C ||
                   lower == krhc_pkg::NUC_G || lower == krhc_pkg::NUC_T;
        endfunction

        // Counts wider than the output port saturate at its maximum.
        function logic [krhc_pkg::OCNT_W-1:0] port_count(input logic [COUNT_WIDTH-1:0] c);
            logic [63:0] wide;
            wide = 64'(c);
            return (wide > 64'hFFFF) ? 16'hFFFF : wide[krhc_pkg::OCNT_W-1:0];
        endfunction

        // Apply one accepted request and queue the result it causes, if any.
        function void take_request(input logic act, input logic [krhc_pkg::BASE_W-1:0] b,
                                   input logic first,
                                   input logic [krhc_pkg::SLOT_W-1:0] idx);
            kmer_reply_t r;
            logic [krhc_pkg::POS_W-1:0] pos;
            logic [31:0] code_mask;
            logic [krhc_pkg::SLOT_W-1:0] slot;

            code_mask = (32'd1 << (2 * KMER_LEN)) - 32'd1;
            if (act == krhc_pkg::ACT_READ) begin
                read_count++;
                r.is_read = 1'b1;
                r.code = idx;
                r.start = '0;
                r.count = port_count(counts[idx]);
                pending.push_back(r);
                return;
            end

            push_count++;
            if (first) begin
                run_len = 0;
                next_pos = '0;
            end
            pos = next_pos;
            next_pos = next_pos + 1;

            // Any non-nucleotide byte breaks the run but still uses a position.
            if (!is_nucleotide(b)) begin
                run_len = 0;
                return;
            end

            // Bits 2:1 of the letter give its 2-bit code.
            window = ((window << 2) | 32'(b[2:1])) & code_mask;
            if (run_len < KMER_LEN) run_len++;
            if (run_len < KMER_LEN) return;

            slot = window[krhc_pkg::SLOT_W-1:0];
            if (counts[slot] != {COUNT_WIDTH{1'b1}}) counts[slot] = counts[slot] + 1'b1;
            r.is_read = 1'b0;
            r.code = slot;
            r.start = pos - (KMER_LEN - 1);
            r.count = port_count(counts[slot]);
            pending.push_back(r);
            seen_slots.push_back(slot);
            if (seen_slots.size() > 64) void'(seen_slots.pop_front());
        endfunction

        // Compare one result against the oldest queued expectation.
        function void check_reply(input logic [0:0] tuser, input logic [63:0] tdata);
            kmer_reply_t got;
            kmer_reply_t want;

            got.is_read = tuser[0];
            got.code = tdata[15:0];
            got.start = tdata[47:16];
            got.count = tdata[63:48];
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: read=%0b code=%h start=%0d count=%0d",
                             got.is_read, got.code, got.start, got.count);
                return;
            end
            want = pending.pop_front();
            if (want.is_read) read_replies++;
            else kmer_results++;
            if (got.is_read !== want.is_read || got.code !== want.code ||
                got.start !== want.start || got.count !== want.count) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Result mismatch: expected read=%0b code=%h start=%0d count=%0d,",
                             want.is_read, want.code, want.start, want.count,
                             " got read=%0b code=%h start=%0d count=%0d",
                             got.is_read, got.code, got.start, got.count);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic [0:0]  m_tuser;

    kmer_tally tally = new();
    bit send_idle;
    bit recv_idle;
    int unsigned requests_sent;

    kmer_rolling_hash_counter #(
        .KMER_LEN   (KMER_LEN),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Present one request, optionally after an idle burst, and wait for acceptance.
    task automatic send_req(input logic act, input logic [krhc_pkg::BASE_W-1:0] b,
                            input logic first, input logic [krhc_pkg::SLOT_W-1:0] idx);
        int gap;
        if (send_idle && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {idx, b};
        s_tuser <= {first, act};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tally.take_request(act, b, first, idx);
        requests_sent++;
    endtask

    // Push one base; the read index is ignored, so it is randomized.
    task automatic push_base(input logic [krhc_pkg::BASE_W-1:0] b, input logic first);
        send_req(krhc_pkg::ACT_PUSH, b, first,
                 krhc_pkg::SLOT_W'($urandom_range(0, TABLE_DEPTH - 1)));
    endtask

    // Read one entry; base and start flag are ignored, so they are randomized.
    task automatic read_slot(input logic [krhc_pkg::SLOT_W-1:0] idx);
        send_req(krhc_pkg::ACT_READ, krhc_pkg::BASE_W'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)), idx);
    endtask

    function automatic logic [krhc_pkg::BASE_W-1:0] letter(input logic [1:0] code);
        logic [krhc_pkg::BASE_W-1:0] b;
        b = LETTER_OF_CODE[code];
        if ($urandom_range(0, 1)) b = b & ~krhc_pkg::CASE_BIT;
        return b;
    endfunction

    function automatic logic [krhc_pkg::BASE_W-1:0] junk_byte();
        logic [krhc_pkg::BASE_W-1:0] b;
        b = krhc_pkg::BASE_W'($urandom_range(0, 255));
        return kmer_tally::is_nucleotide(b) ? NOT_A_BASE : b;
    endfunction

    // A run of bases, either fully random or a short repeating motif, with rare junk.
    task automatic push_sequence(input int len, input bit start_new);
        logic [1:0] motif [4];
        int period;
        logic [krhc_pkg::BASE_W-1:0] b;
        for (int k = 0; k < 4; k++) motif[k] = 2'($urandom_range(0, 3));
        period = $urandom_range(0, 1) ? $urandom_range(1, 4) : 0;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 29) == 0) b = junk_byte();
            else if (period == 0) b = letter(2'($urandom_range(0, 3)));
            else b = letter(motif[i % period]);
            push_base(b, start_new && i == 0);
        end
    endtask

    // Result side: check accepted results and apply random stall bursts.
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) tally.check_reply(m_tuser, m_tdata);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (recv_idle && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(1, 17) - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Safety net against a hung block.
    initial begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

    // Stimulus and end of run.
    initial begin
        int sel;
        int chunk_end;
        int mode;

        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        send_idle = 1'b1;
        recv_idle = 1'b1;
        requests_sent = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: a first k-mer in mixed case, its sliding neighbor, junk bytes,
        // a sequence restart on a junk byte, reads at both table ends.
        push_base(krhc_pkg::NUC_A & ~krhc_pkg::CASE_BIT, 1'b1);
        push_base(krhc_pkg::NUC_C & ~krhc_pkg::CASE_BIT, 1'b0);
        push_base(krhc_pkg::NUC_G & ~krhc_pkg::CASE_BIT, 1'b0);
        push_base(krhc_pkg::NUC_T & ~krhc_pkg::CASE_BIT, 1'b0);
        push_base(krhc_pkg::NUC_A, 1'b0);
        push_base(krhc_pkg::NUC_C, 1'b0);
        push_base(krhc_pkg::NUC_G, 1'b0);
        send_req(krhc_pkg::ACT_PUSH, krhc_pkg::NUC_T, 1'b0, 16'hFFFF);
        push_base(krhc_pkg::NUC_T & ~krhc_pkg::CASE_BIT, 1'b0);
        push_base(NOT_A_BASE, 1'b0);
        push_base(8'h00, 1'b0);
        push_base(8'hFF, 1'b0);
        for (int i = 0; i < KMER_LEN; i++)
            push_base(i == 3 ? krhc_pkg::NUC_G : krhc_pkg::NUC_G & ~krhc_pkg::CASE_BIT, 1'b0);
        read_slot(tally.seen_slots[0]);
        read_slot(16'h0000);
        send_req(krhc_pkg::ACT_READ, 8'hFF, 1'b1, 16'hFFFF);
        push_base(NOT_A_BASE, 1'b1);

        // Random: mostly well-formed sequences, plus reads and noise, in chunks
        // with different idling on each side; the last chunk has none.
        for (int chunk = 0; chunk < 9; chunk++) begin
            mode = (chunk == 8) ? 0 : $urandom_range(0, 3);
            send_idle = mode[0];
            recv_idle = mode[1];
            if (chunk < 4 && chunk > 0) begin
                send_idle = 1'b1;
                recv_idle = 1'b1;
            end
            chunk_end = int'(requests_sent) + RANDOM_ITEMS / 9;
            while (int'(requests_sent) < chunk_end) begin
                sel = $urandom_range(0, 99);
                if (sel < 60) begin
                    push_sequence($urandom_range(KMER_LEN, 40), $urandom_range(0, 9) != 0);
                end else if (sel < 85) begin
                    if (tally.seen_slots.size() > 0 && $urandom_range(0, 9) < 7)
                        read_slot(tally.seen_slots[$urandom_range(0,
                                                   tally.seen_slots.size() - 1)]);
                    else
                        read_slot(krhc_pkg::SLOT_W'($urandom_range(0, TABLE_DEPTH - 1)));
                end else begin
                    repeat ($urandom_range(1, 5))
                        push_base(krhc_pkg::BASE_W'($urandom_range(0, 255)),
                                  $urandom_range(0, 3) == 0);
                end
            end
        end
        s_tvalid <= 1'b0;

        // Drain the outstanding results, then allow a few more cycles.
        while (tally.pending.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Run covered %0d base pushes and %0d table reads, with restarts,",
                 tally.push_count, tally.read_count,
                 " junk bytes and stalls on both sides.");
        $display("Checked %0d k-mer results and %0d read replies; %0d mismatches.",
                 tally.kmer_results, tally.read_replies, tally.mismatches);
        if (tally.mismatches == 0 && tally.pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### files.f
sv/krhc_pkg.sv
sv/krhc_window.sv
sv/krhc_table.sv
sv/kmer_rolling_hash_counter.sv
tb/kmer_rolling_hash_counter_test.sv
